[sv/scfl_pkg.sv]
package scfl_pkg;

	localparam int NUM_CLASSES = 6;
	localparam int STACK_DEPTH = 64;
	localparam int ADDR_WIDTH  = 32;
	localparam int SIZE_WIDTH  = 16;
	localparam int CLS_W       = 3;
	localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
	localparam int MEM_DEPTH   = NUM_CLASSES * STACK_DEPTH;
	localparam int MEM_AW      = $clog2(MEM_DEPTH);
	localparam int CMD_Q_DEPTH = 4;
	localparam int CMD_Q_AW    = $clog2(CMD_Q_DEPTH);
	localparam int RES_Q_DEPTH = 4;
	localparam int RES_Q_AW    = $clog2(RES_Q_DEPTH);

	localparam logic [CLS_W-1:0] OVERSIZE_CLASS = 3'd6;

	localparam logic REQ_ALLOC   = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	localparam logic [1:0] ST_REUSE = 2'd0;
	localparam logic [1:0] ST_FRESH = 2'd1;
	localparam logic [1:0] ST_KEPT  = 2'd2;
	localparam logic [1:0] ST_HEAP  = 2'd3;

	typedef struct packed {
		logic                  is_release;
		logic [CLS_W-1:0]      cls;
		logic [SIZE_WIDTH-1:0] size;
		logic [ADDR_WIDTH-1:0] addr;
	} cmd_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [ADDR_WIDTH-1:0] block_address;
		logic [SIZE_WIDTH-1:0] fresh_size;
		logic [CLS_W-1:0]      size_class;
	} result_t;

	function automatic logic [SIZE_WIDTH-1:0] class_slots(input logic [CLS_W-1:0] c);
		logic [SIZE_WIDTH-1:0] slots;
		unique case (c)
			3'd0: slots = SIZE_WIDTH'(4);
			3'd1: slots = SIZE_WIDTH'(16);
			3'd2: slots = SIZE_WIDTH'(64);
			3'd3: slots = SIZE_WIDTH'(128);
			3'd4: slots = SIZE_WIDTH'(256);
			3'd5: slots = SIZE_WIDTH'(512);
			default: slots = '0;
		endcase
		return slots;
	endfunction

	function automatic logic [CLS_W-1:0] class_of(input logic [SIZE_WIDTH-1:0] size);
		logic [CLS_W-1:0] cls;
		cls = OVERSIZE_CLASS;
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if (size <= class_slots(CLS_W'(c))) begin
				cls = CLS_W'(c);
			end
		end
		return cls;
	endfunction

endpackage

[sv/size_class_free_list_allocator.sv]
// When both queues are empty, a pushed beat passes the front queue, the stage-two registers and the result queue.
// Throughput: one beat per cycle while the result queue has room; each beat does at most one stack push or pop.
// The front queue holds four classified requests and the result queue holds four results.
// Reset clears the stack fill counts and all queue and pipeline control at once.
// The address memory is not cleared; no entry is read before a push has written it.
module size_class_free_list_allocator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic                                 req_type,
	input  logic [14:0]                          template_count,
	input  logic [14:0]                          arg_count,
	input  logic [scfl_pkg::SIZE_WIDTH-1:0]      release_size,
	input  logic [scfl_pkg::ADDR_WIDTH-1:0]      release_address,
	output logic                                 empty,
	input  logic                                 pop,
	output logic [1:0]                           status,
	output logic [scfl_pkg::ADDR_WIDTH-1:0]      block_address,
	output logic [scfl_pkg::SIZE_WIDTH-1:0]      fresh_size,
	output logic [2:0]                           size_class
);

	logic           cmd_valid;
	logic           cmd_ready;
	scfl_pkg::cmd_t cmd;

	scfl_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.req_type        (req_type),
		.template_count  (template_count),
		.arg_count       (arg_count),
		.release_size    (release_size),
		.release_address (release_address),
		.cmd_valid       (cmd_valid),
		.cmd             (cmd),
		.cmd_ready       (cmd_ready)
	);

	scfl_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd),
		.cmd_ready     (cmd_ready),
		.empty         (empty),
		.pop           (pop),
		.status        (status),
		.block_address (block_address),
		.fresh_size    (fresh_size),
		.size_class    (size_class)
	);

endmodule

[sv/scfl_front.sv]
module scfl_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic                                 req_type,
	input  logic [14:0]                          template_count,
	input  logic [14:0]                          arg_count,
	input  logic [scfl_pkg::SIZE_WIDTH-1:0]      release_size,
	input  logic [scfl_pkg::ADDR_WIDTH-1:0]      release_address,
	output logic                                 cmd_valid,
	output scfl_pkg::cmd_t                       cmd,
	input  logic                                 cmd_ready
);

	scfl_pkg::cmd_t entries_q [scfl_pkg::CMD_Q_DEPTH];
	scfl_pkg::cmd_t cmd_in;
	logic [scfl_pkg::CMD_Q_AW-1:0] wr_ptr_q;
	logic [scfl_pkg::CMD_Q_AW-1:0] rd_ptr_q;
	logic [scfl_pkg::CMD_Q_AW:0]   count_q;
	logic [scfl_pkg::SIZE_WIDTH-1:0] need;
	logic push_ok;
	logic pop_ok;

	// The two 15-bit counts cannot overflow the 16-bit size field.
	assign need = scfl_pkg::SIZE_WIDTH'({1'b0, template_count})
		+ scfl_pkg::SIZE_WIDTH'({1'b0, arg_count});

	always_comb begin
		cmd_in.is_release = (req_type == scfl_pkg::REQ_RELEASE);
		cmd_in.size       = cmd_in.is_release ? release_size : need;
		cmd_in.cls        = scfl_pkg::class_of(cmd_in.size);
		cmd_in.addr       = release_address;
	end

	assign full      = (count_q == (scfl_pkg::CMD_Q_AW + 1)'(scfl_pkg::CMD_Q_DEPTH));
	assign cmd_valid = (count_q != '0);
	assign cmd       = entries_q[rd_ptr_q];
	assign push_ok   = push && !full;
	assign pop_ok    = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == scfl_pkg::CMD_Q_AW'(scfl_pkg::CMD_Q_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == scfl_pkg::CMD_Q_AW'(scfl_pkg::CMD_Q_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push_ok && !pop_ok) begin
				count_q <= count_q + 1'b1;
			end else if (pop_ok && !push_ok) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			entries_q[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

[sv/scfl_back.sv]
module scfl_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cmd_valid,
	input  scfl_pkg::cmd_t                       cmd,
	output logic                                 cmd_ready,
	output logic                                 empty,
	input  logic                                 pop,
	output logic [1:0]                           status,
	output logic [scfl_pkg::ADDR_WIDTH-1:0]      block_address,
	output logic [scfl_pkg::SIZE_WIDTH-1:0]      fresh_size,
	output logic [2:0]                           size_class
);

	localparam int CLS_W  = scfl_pkg::CLS_W;
	localparam int FILL_W = scfl_pkg::FILL_W;
	localparam int MEM_AW = scfl_pkg::MEM_AW;
	localparam int RQ_AW  = scfl_pkg::RES_Q_AW;

	logic [scfl_pkg::ADDR_WIDTH-1:0] mem [scfl_pkg::MEM_DEPTH];
	logic [scfl_pkg::ADDR_WIDTH-1:0] rdata_q;
	logic [FILL_W-1:0] fill_q [scfl_pkg::NUM_CLASSES];

	logic [scfl_pkg::NUM_CLASSES-1:0] hit;
	logic              found;
	logic [CLS_W-1:0]  pick_cls;
	logic [FILL_W-1:0] rel_fill;
	logic              rel_ok;
	logic              go;
	logic              mem_we;
	logic              mem_re;
	logic [CLS_W-1:0]  mem_cls;
	logic [FILL_W-1:0] mem_idx;
	logic [MEM_AW-1:0] mem_addr;

	logic                             valid_s2;
	logic                             use_mem_s2;
	logic [1:0]                       status_s2;
	logic [CLS_W-1:0]                 cls_s2;
	logic [scfl_pkg::SIZE_WIDTH-1:0]  fresh_s2;
	logic [1:0]                       status_d;
	logic [CLS_W-1:0]                 cls_d;
	logic [scfl_pkg::SIZE_WIDTH-1:0]  fresh_d;

	scfl_pkg::result_t res_q [scfl_pkg::RES_Q_DEPTH];
	scfl_pkg::result_t res_in;
	logic [RQ_AW-1:0] res_wr_q;
	logic [RQ_AW-1:0] res_rd_q;
	logic [RQ_AW:0]   res_count_q;
	logic [RQ_AW+1:0] res_used;
	logic             res_pop;

	always_comb begin
		for (int c = 0; c < scfl_pkg::NUM_CLASSES; c++) begin
			hit[c] = (CLS_W'(c) >= cmd.cls) && (fill_q[c] != '0);
		end
		found    = 1'b0;
		pick_cls = scfl_pkg::OVERSIZE_CLASS;
		for (int c = scfl_pkg::NUM_CLASSES - 1; c >= 0; c--) begin
			if (hit[c]) begin
				found    = 1'b1;
				pick_cls = CLS_W'(c);
			end
		end
	end

	assign rel_fill = (cmd.cls != scfl_pkg::OVERSIZE_CLASS) ? fill_q[cmd.cls] : '0;
	assign rel_ok   = (cmd.cls != scfl_pkg::OVERSIZE_CLASS)
		&& (rel_fill < FILL_W'(scfl_pkg::STACK_DEPTH));

	// A slot is reserved in the result queue for every beat still in flight.
	assign res_used  = (RQ_AW + 2)'(res_count_q) + (RQ_AW + 2)'(valid_s2);
	assign cmd_ready = (res_used < (RQ_AW + 2)'(scfl_pkg::RES_Q_DEPTH));
	assign go        = cmd_valid && cmd_ready;
	assign mem_we    = go && cmd.is_release && rel_ok;
	assign mem_re    = go && !cmd.is_release && found;

	assign mem_cls  = cmd.is_release ? cmd.cls : pick_cls;
	assign mem_idx  = cmd.is_release ? rel_fill : fill_q[pick_cls] - 1'b1;
	assign mem_addr = MEM_AW'(mem_cls) * MEM_AW'(scfl_pkg::STACK_DEPTH) + MEM_AW'(mem_idx);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= cmd.addr;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_addr];
		end
	end

	always_comb begin
		fresh_d = '0;
		if (cmd.is_release) begin
			cls_d    = cmd.cls;
			status_d = rel_ok ? scfl_pkg::ST_KEPT : scfl_pkg::ST_HEAP;
		end else if (found) begin
			cls_d    = pick_cls;
			status_d = scfl_pkg::ST_REUSE;
		end else begin
			cls_d    = cmd.cls;
			status_d = scfl_pkg::ST_FRESH;
			fresh_d  = (cmd.cls == scfl_pkg::OVERSIZE_CLASS) ?
				cmd.size : scfl_pkg::class_slots(cmd.cls);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			for (int c = 0; c < scfl_pkg::NUM_CLASSES; c++) begin
				fill_q[c] <= '0;
			end
		end else begin
			valid_s2 <= go;
			if (mem_re) begin
				fill_q[pick_cls] <= fill_q[pick_cls] - 1'b1;
			end
			if (mem_we) begin
				fill_q[cmd.cls] <= rel_fill + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			use_mem_s2 <= mem_re;
			status_s2  <= status_d;
			cls_s2     <= cls_d;
			fresh_s2   <= fresh_d;
		end
	end

	always_comb begin
		res_in.status        = status_s2;
		res_in.block_address = use_mem_s2 ? rdata_q : '0;
		res_in.fresh_size    = fresh_s2;
		res_in.size_class    = cls_s2;
	end

	assign empty   = (res_count_q == '0);
	assign res_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q    <= '0;
			res_rd_q    <= '0;
			res_count_q <= '0;
		end else begin
			if (valid_s2) begin
				res_wr_q <= (res_wr_q == RQ_AW'(scfl_pkg::RES_Q_DEPTH - 1)) ?
					'0 : res_wr_q + 1'b1;
			end
			if (res_pop) begin
				res_rd_q <= (res_rd_q == RQ_AW'(scfl_pkg::RES_Q_DEPTH - 1)) ?
					'0 : res_rd_q + 1'b1;
			end
			if (valid_s2 && !res_pop) begin
				res_count_q <= res_count_q + 1'b1;
			end else if (res_pop && !valid_s2) begin
				res_count_q <= res_count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			res_q[res_wr_q] <= res_in;
		end
	end

	assign status        = res_q[res_rd_q].status;
	assign block_address = res_q[res_rd_q].block_address;
	assign fresh_size    = res_q[res_rd_q].fresh_size;
	assign size_class    = res_q[res_rd_q].size_class;

endmodule
